[hdl/hse_pkg.sv]
package hse_pkg;

    localparam int KCNT_W   = 7;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = 40;
    localparam int PROD_W   = ACC_W + FRAC_W + 1;
    localparam int RND_HALF = 1 << (FRAC_W - 1);
    localparam int KNOT_W   = 2 * DATA_W;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t ACC_HI = acc_t'($signed(32'h7FFF_FFFF));
    localparam acc_t ACC_LO = acc_t'($signed(32'h8000_0000));

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         knot_index;
        logic signed [DATA_W-1:0] knot_value;
        logic signed [DATA_W-1:0] knot_slope;
        logic [FRAC_W-1:0]        position;
        logic                     last_in;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] spline_value;
        logic                     saturated;
        logic                     last_out;
    } out_t;

    typedef struct packed {
        logic [FRAC_W-1:0]        t;
        logic signed [DATA_W-1:0] m0;
        logic signed [DATA_W-1:0] p0;
        logic                     last;
    } side_t;

endpackage

[hdl/hse_ram.sv]
module hse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/hse_horner_step.sv]
module hse_horner_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          v_in,
    input  hse_pkg::acc_t  acc_in,
    input  hse_pkg::acc_t  add_in,
    input  hse_pkg::side_t side_in,
    output logic          v_out,
    output hse_pkg::acc_t  acc_out,
    output hse_pkg::side_t side_out
);

    import hse_pkg::*;

    logic                     v_a_reg;
    logic                     v_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     add_reg;
    side_t                    side_a_reg;
    acc_t                     acc_b_reg;
    side_t                    side_b_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd_sum;
    acc_t                     acc_next;

    always_comb begin
        prod_next = acc_in * $signed({1'b0, side_in.t});
        rnd_sum   = prod_reg + PROD_W'(RND_HALF);
        acc_next  = acc_t'(rnd_sum[PROD_W-1:FRAC_W]) + add_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end else if (en) begin
            v_a_reg <= v_in;
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= prod_next;
            add_reg    <= add_in;
            side_a_reg <= side_in;
            acc_b_reg  <= acc_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign v_out    = v_b_reg;
    assign acc_out  = acc_b_reg;
    assign side_out = side_b_reg;

endmodule

[hdl/hermite_spline_evaluator_unit.sv]
// Cubic Hermite spline evaluator over uniformly spaced knots on [0,1).
//
// Input channel (s_valid/s_ready/s_data): a load request (action 0) stores one
// knot's value and slope; an evaluate request (action 1) carries a Q0.16
// position and yields one result on the m_ channel. Loads yield nothing.
// Config channel (cfg_valid/cfg_ready/cfg_data): knot count, always ready;
// write it only while no request is in flight.
//
// Pipeline: a request passes the bin multiply, table read, coefficient
// build, then three Horner steps of two stages each (multiply, then round
// and add), and the saturating output stage before it shows on m_valid.
// Throughput: one request per cycle while s_ready is high, set by the
// fully pipelined datapath and the dual-read knot table.
//
// Reset clears the pipeline valid bits and sets the knot count to 2; knot
// tables keep their contents and must be loaded before use.
// When m_ready is low the result holds on m_data; one more result drops into
// a skid register, then s_ready falls and the whole pipeline holds until the
// skid register drains. Nothing is lost or repeated across a stall.
module hermite_spline_evaluator_unit #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hse_pkg::KCNT_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hse_pkg::in_t                s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output hse_pkg::out_t               m_data
);

    import hse_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int PW = FRAC_W + AW;

    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    int            n_cfg;

    logic adv;
    logic accept;

    logic [PW-1:0]     pos_prod;
    logic              v1_reg;
    logic              act1_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic [DATA_W-1:0] value1_reg;
    logic [DATA_W-1:0] slope1_reg;
    logic [AW-1:0]     bin1_reg;
    logic [FRAC_W-1:0] frac1_reg;
    logic              last1_reg;

    logic              tbl_we;
    logic [AW-1:0]     tbl_waddr;
    logic [KNOT_W-1:0] rd_a;
    logic [KNOT_W-1:0] rd_b;

    logic              v2_reg;
    logic [FRAC_W-1:0] frac2_reg;
    logic              last2_reg;

    acc_t  p0_x;
    acc_t  m0_x;
    acc_t  p1_x;
    acc_t  m1_x;
    acc_t  dp_x;
    acc_t  c2_next;
    acc_t  c3_next;
    side_t side3_next;

    logic  v3_reg;
    acc_t  c2_reg;
    acc_t  c3_reg;
    side_t side3_reg;

    logic  v5;
    acc_t  acc5;
    side_t side5;
    logic  v7;
    acc_t  acc7;
    side_t side7;
    logic  v9;
    acc_t  acc9;
    side_t side9;

    out_t res_next;
    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;

    // knot count, clamped to [2, MAX_KNOTS], held as bin count
    always_comb begin
        n_cfg = int'(cfg_data);
        if (n_cfg < 2) begin
            n_cfg = 2;
        end
        if (n_cfg > MAX_KNOTS) begin
            n_cfg = MAX_KNOTS;
        end
        k_next = AW'(n_cfg - 1);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= AW'(1);
        end else if (cfg_valid && cfg_ready) begin
            k_reg <= k_next;
        end
    end

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    assign pos_prod = PW'(s_data.position) * PW'(k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept;
            v2_reg <= v1_reg && (act1_reg == ACT_EVAL);
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            act1_reg   <= s_data.action;
            idx1_reg   <= s_data.knot_index;
            value1_reg <= s_data.knot_value;
            slope1_reg <= s_data.knot_slope;
            bin1_reg   <= pos_prod[PW-1:FRAC_W];
            frac1_reg  <= pos_prod[FRAC_W-1:0];
            last1_reg  <= s_data.last_in;
            frac2_reg  <= frac1_reg;
            last2_reg  <= last1_reg;
            c2_reg     <= c2_next;
            c3_reg     <= c3_next;
            side3_reg  <= side3_next;
        end
    end

    // loads write and evaluates read at the same stage, so order holds
    assign tbl_we    = adv && v1_reg && (act1_reg == ACT_LOAD)
                       && (int'(idx1_reg) < MAX_KNOTS);
    assign tbl_waddr = AW'(idx1_reg);

    hse_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (MAX_KNOTS)
    ) u_knot_ram (
        .aclk    (aclk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   ({value1_reg, slope1_reg}),
        .re      (adv),
        .raddr_a (bin1_reg),
        .raddr_b (bin1_reg + AW'(1)),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb begin
        p0_x    = acc_t'($signed(rd_a[KNOT_W-1:DATA_W]));
        m0_x    = acc_t'($signed(rd_a[DATA_W-1:0]));
        p1_x    = acc_t'($signed(rd_b[KNOT_W-1:DATA_W]));
        m1_x    = acc_t'($signed(rd_b[DATA_W-1:0]));
        dp_x    = p1_x - p0_x;
        c2_next = (dp_x <<< 1) + dp_x - (m0_x <<< 1) - m1_x;
        c3_next = m0_x + m1_x - (dp_x <<< 1);
        side3_next.t    = frac2_reg;
        side3_next.m0   = rd_a[DATA_W-1:0];
        side3_next.p0   = rd_a[KNOT_W-1:DATA_W];
        side3_next.last = last2_reg;
    end

    hse_horner_step u_step_c3 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .v_in     (v3_reg),
        .acc_in   (c3_reg),
        .add_in   (c2_reg),
        .side_in  (side3_reg),
        .v_out    (v5),
        .acc_out  (acc5),
        .side_out (side5)
    );

    hse_horner_step u_step_c2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .v_in     (v5),
        .acc_in   (acc5),
        .add_in   (acc_t'(side5.m0)),
        .side_in  (side5),
        .v_out    (v7),
        .acc_out  (acc7),
        .side_out (side7)
    );

    hse_horner_step u_step_c1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .v_in     (v7),
        .acc_in   (acc7),
        .add_in   (acc_t'(side7.p0)),
        .side_in  (side7),
        .v_out    (v9),
        .acc_out  (acc9),
        .side_out (side9)
    );

    always_comb begin
        res_next.last_out = side9.last;
        if (acc9 > ACC_HI) begin
            res_next.spline_value = ACC_HI[DATA_W-1:0];
            res_next.saturated    = 1'b1;
        end else if (acc9 < ACC_LO) begin
            res_next.spline_value = ACC_LO[DATA_W-1:0];
            res_next.saturated    = 1'b1;
        end else begin
            res_next.spline_value = acc9[DATA_W-1:0];
            res_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= v9;
            end
        end else if (adv && v9) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= res_next;
            end
        end else if (adv && v9) begin
            skid_data_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[hdl/hse_checker.sv]
module hse_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [hse_pkg::KCNT_W-1:0] cfg_data,
    input logic                       s_valid,
    input logic                       s_ready,
    input hse_pkg::in_t                s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input hse_pkg::out_t               m_data
);

    import hse_pkg::*;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.spline_value == 32'h7FFF_FFFF) ||
            (m_data.spline_value == 32'h8000_0000))
        else $error("saturated flag without clipped value");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the pipeline");

    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input held off with no result pending");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input held off without an output stall");

endmodule

bind hermite_spline_evaluator_unit hse_checker u_hse_checker (.*);
